>>> sv/lse_pkg.sv
package lse_pkg;

  localparam int unsigned COORD_W    = 20;
  localparam int unsigned INTEN_W    = 16;
  localparam int unsigned THR_W      = 19;
  localparam int unsigned SCAN_W     = 7;
  localparam int unsigned LINE_NUM_W = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = THR_W;
  localparam int unsigned SQ_W       = 2 * COORD_W - 1;
  localparam int unsigned SUM_W      = SQ_W + 2;
  localparam int unsigned THR_SQ_W   = 2 * THR_W;
  localparam int unsigned DX_W       = COORD_W + 1;

  localparam logic [THR_W-1:0]    DEPTH_THR_RST = '0;
  localparam logic [THR_W-1:0]    DIST_THR_RST  = 19'h7FFFF;
  localparam logic [THR_SQ_W-1:0] DIST_SQ_RST   = 38'd274876858369;
  localparam logic [THR_W-1:0]    EDGE_THR_RST  = '0;
  localparam logic [INTEN_W-1:0]  INTEN_THR_RST = '0;
  localparam logic [SCAN_W-1:0]   SCAN_CNT_RST  = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_THR = 3'd0,
    REG_DIST_THR  = 3'd1,
    REG_EDGE_THR  = 3'd2,
    REG_INTEN_THR = 3'd3,
    REG_SCAN_CNT  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic                      frame_start;
    logic                      finite;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [INTEN_W-1:0]        inten;
  } raw_pt_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [INTEN_W-1:0]        inten;
    logic                      near;
  } point_t;

  typedef struct packed {
    logic   frame_start;
    logic   keep;
    point_t pt;
  } staged_t;

endpackage

>>> sv/lse_point_if.sv
interface lse_point_if;
  import lse_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      frame_start;
  logic                      finite;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic signed [COORD_W-1:0] z_coord;
  logic [INTEN_W-1:0]        intensity;

  modport source (
    output valid, frame_start, finite, x_coord, y_coord, z_coord, intensity,
    input  ready
  );
  modport sink (
    input  valid, frame_start, finite, x_coord, y_coord, z_coord, intensity,
    output ready
  );
endinterface

>>> sv/lse_edge_if.sv
interface lse_edge_if;
  import lse_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] edge_x;
  logic signed [COORD_W-1:0] edge_y;
  logic signed [COORD_W-1:0] edge_z;
  logic [INTEN_W-1:0]        edge_intensity;
  logic [LINE_NUM_W-1:0]     line_number;

  modport source (
    output valid, edge_x, edge_y, edge_z, edge_intensity, line_number,
    input  ready
  );
  modport sink (
    input  valid, edge_x, edge_y, edge_z, edge_intensity, line_number,
    output ready
  );
endinterface

>>> sv/lse_cfg_if.sv
interface lse_cfg_if;
  import lse_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/lse_range.sv
module lse_range (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  lse_pkg::raw_pt_t                 in_pt_i,
  input  logic [lse_pkg::THR_SQ_W-1:0]     depth_sq_i,
  input  logic [lse_pkg::THR_SQ_W-1:0]     dist_sq_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output lse_pkg::staged_t                 out_pt_o
);
  import lse_pkg::*;

  logic                         s1_valid_q;
  raw_pt_t                      s1_pt_q;
  logic [SQ_W-1:0]              xx_q, yy_q, zz_q;
  logic [SQ_W-1:0]              xx_full, yy_full, zz_full;
  logic                         s1_en, s2_en;
  logic                         s2_valid_q;
  staged_t                      s2_q;
  logic [SUM_W-1:0]             sum;

  assign s2_en      = !s2_valid_q || out_ready_i;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  assign xx_full = SQ_W'((2*COORD_W)'(in_pt_i.x) * (2*COORD_W)'(in_pt_i.x));
  assign yy_full = SQ_W'((2*COORD_W)'(in_pt_i.y) * (2*COORD_W)'(in_pt_i.y));
  assign zz_full = SQ_W'((2*COORD_W)'(in_pt_i.z) * (2*COORD_W)'(in_pt_i.z));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_pt_q <= in_pt_i;
      xx_q    <= xx_full;
      yy_q    <= yy_full;
      zz_q    <= zz_full;
    end
  end

  assign sum = SUM_W'(xx_q) + SUM_W'(yy_q) + SUM_W'(zz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      s2_q.frame_start <= s1_pt_q.frame_start;
      s2_q.keep        <= s1_pt_q.finite && (sum > SUM_W'(depth_sq_i));
      s2_q.pt.x        <= s1_pt_q.x;
      s2_q.pt.y        <= s1_pt_q.y;
      s2_q.pt.z        <= s1_pt_q.z;
      s2_q.pt.inten    <= s1_pt_q.inten;
      s2_q.pt.near     <= sum <= SUM_W'(dist_sq_i);
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_pt_o    = s2_q;

endmodule

>>> sv/lse_cell.sv
module lse_cell (
  input  logic            clk_i,
  input  logic            load_i,
  input  lse_pkg::point_t d_i,
  output lse_pkg::point_t q_o
);
  import lse_pkg::*;

  point_t pt_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pt_q <= d_i;
    end
  end

  assign q_o = pt_q;

endmodule

>>> sv/lidar_scanline_edge_extractor.sv
// Lidar scan-line edge extractor.
// point_i takes one lidar point per transaction (frame marker, finite flag,
// x/y/z in millimetres, intensity). edge_o gives one edge point per
// transaction, tagged with its scan line. cfg_i writes the threshold and
// line-count registers; it is always ready and must only be used while no
// point is in flight.
// Throughput: one point per cycle while edge_o does not stall. A point passes
// a squaring stage, a range sum/compare stage and then the two-cell window
// row; an edge is written to the output register as its "next" neighbour
// passes from the range stages into the window row.
// When edge_o stalls, the output register holds its edge and the two range
// stages keep filling, so up to two more points are accepted before
// point_i.ready drops.
// Reset clears the pipeline, window fill, line counter and angle history and
// loads the register defaults; there is no clearing pass.
module lidar_scanline_edge_extractor #(
  parameter int unsigned MAX_LINES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lse_point_if.sink  point_i,
  lse_edge_if.source edge_o,
  lse_cfg_if.sink    cfg_i
);
  import lse_pkg::*;

  localparam int unsigned LINE_W = $clog2(MAX_LINES + 1);
  localparam int unsigned CMP_W  = (LINE_W > SCAN_W) ? LINE_W : SCAN_W;

  logic [THR_W-1:0]    edge_thr_q;
  logic [INTEN_W-1:0]  inten_thr_q;
  logic [SCAN_W-1:0]   scan_cnt_q;
  logic [THR_SQ_W-1:0] depth_sq_q, dist_sq_q, wr_sq;
  logic                cfg_fire;

  raw_pt_t             in_pt;
  staged_t             st;
  logic                st_valid, fire3;

  logic [1:0]          fill_q, fill_d;
  logic                pan_q, pan_d, hp_q, hp_d;
  logic [LINE_W-1:0]   line_q, line_d;
  logic [CMP_W-1:0]    limit;
  point_t              cell0, cell1, cell0_d;
  logic                load0, load1;

  logic                neg, pos, emit;
  logic [INTEN_W-1:0]  gi_a, gi_p, gi;
  logic signed [DX_W-1:0] dx_a, dx_p, dx;

  logic                out_valid_q;
  point_t              out_pt_q;
  logic [LINE_W-1:0]   out_line_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign wr_sq       = THR_SQ_W'(cfg_i.data) * THR_SQ_W'(cfg_i.data);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_thr_q  <= EDGE_THR_RST;
      inten_thr_q <= INTEN_THR_RST;
      scan_cnt_q  <= SCAN_CNT_RST;
      depth_sq_q  <= '0;
      dist_sq_q   <= DIST_SQ_RST;
    end else if (cfg_fire) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_DEPTH_THR: depth_sq_q  <= wr_sq;
        REG_DIST_THR:  dist_sq_q   <= wr_sq;
        REG_EDGE_THR:  edge_thr_q  <= cfg_i.data;
        REG_INTEN_THR: inten_thr_q <= cfg_i.data[INTEN_W-1:0];
        REG_SCAN_CNT:  scan_cnt_q  <= cfg_i.data[SCAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_pt.frame_start = point_i.frame_start;
  assign in_pt.finite      = point_i.finite;
  assign in_pt.x           = point_i.x_coord;
  assign in_pt.y           = point_i.y_coord;
  assign in_pt.z           = point_i.z_coord;
  assign in_pt.inten       = point_i.intensity;

  lse_range u_range (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (point_i.valid),
    .in_ready_o  (point_i.ready),
    .in_pt_i     (in_pt),
    .depth_sq_i  (depth_sq_q),
    .dist_sq_i   (dist_sq_q),
    .out_valid_o (st_valid),
    .out_ready_i (fire3),
    .out_pt_o    (st)
  );

  assign fire3 = st_valid && (!out_valid_q || edge_o.ready);

  lse_cell u_cell0 (
    .clk_i  (clk_i),
    .load_i (load0),
    .d_i    (cell0_d),
    .q_o    (cell0)
  );

  lse_cell u_cell1 (
    .clk_i  (clk_i),
    .load_i (load1),
    .d_i    (st.pt),
    .q_o    (cell1)
  );

  assign gi_a = (cell0.inten > cell1.inten) ? cell0.inten - cell1.inten
                                            : cell1.inten - cell0.inten;
  assign gi_p = (st.pt.inten > cell1.inten) ? st.pt.inten - cell1.inten
                                            : cell1.inten - st.pt.inten;
  assign gi   = (gi_p > gi_a) ? gi_p : gi_a;
  assign dx_a = DX_W'(cell0.x) - DX_W'(cell1.x);
  assign dx_p = DX_W'(st.pt.x) - DX_W'(cell1.x);
  assign dx   = (dx_p > dx_a) ? dx_p : dx_a;

  assign neg   = st.pt.y[COORD_W-1];
  assign pos   = (!st.pt.y[COORD_W-1] && (st.pt.y != '0))
              || ((st.pt.y == '0) && st.pt.x[COORD_W-1]);
  assign limit = (CMP_W'(scan_cnt_q) < CMP_W'(MAX_LINES)) ? CMP_W'(scan_cnt_q)
                                                          : CMP_W'(MAX_LINES);

  always_comb begin
    fill_d  = st.frame_start ? 2'd0 : fill_q;
    pan_d   = st.frame_start ? 1'b0 : pan_q;
    hp_d    = st.frame_start ? 1'b0 : hp_q;
    line_d  = st.frame_start ? '0 : line_q;
    load0   = 1'b0;
    load1   = 1'b0;
    cell0_d = cell1;
    emit    = 1'b0;
    if (st.keep) begin
      if (hp_d && pan_d && pos) begin
        fill_d = 2'd0;
        if (line_d < LINE_W'(MAX_LINES)) begin
          line_d = line_d + 1'b1;
        end
      end
      hp_d  = 1'b1;
      pan_d = neg;
      if (CMP_W'(line_d) < limit) begin
        case (fill_d)
          2'd0: begin
            load0   = 1'b1;
            cell0_d = st.pt;
            fill_d  = 2'd1;
          end
          2'd1: begin
            load1  = 1'b1;
            fill_d = 2'd2;
          end
          default: begin
            load0 = 1'b1;
            load1 = 1'b1;
            emit  = !cell1.x[COORD_W-1] && cell1.near && (gi > inten_thr_q)
                 && (dx > $signed({2'b00, edge_thr_q}));
          end
        endcase
      end
    end
    if (!fire3) begin
      fill_d = fill_q;
      pan_d  = pan_q;
      hp_d   = hp_q;
      line_d = line_q;
      load0  = 1'b0;
      load1  = 1'b0;
      emit   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
      pan_q  <= 1'b0;
      hp_q   <= 1'b0;
      line_q <= '0;
    end else begin
      fill_q <= fill_d;
      pan_q  <= pan_d;
      hp_q   <= hp_d;
      line_q <= line_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire3) begin
      out_valid_q <= emit;
    end else if (edge_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_pt_q   <= cell1;
      out_line_q <= line_d;
    end
  end

  assign edge_o.valid          = out_valid_q;
  assign edge_o.edge_x         = out_pt_q.x;
  assign edge_o.edge_y         = out_pt_q.y;
  assign edge_o.edge_z         = out_pt_q.z;
  assign edge_o.edge_intensity = out_pt_q.inten;
  assign edge_o.line_number    = LINE_NUM_W'(out_line_q);

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 2'd3)
    else $error("window fill out of range");

  a_line_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q <= LINE_W'(MAX_LINES))
    else $error("line counter beyond limit");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire3 && st.frame_start) |=> (line_q == '0))
    else $error("frame start did not reset line counter");

  a_emit_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (fire3 && load0 && load1 && (fill_d == 2'd2)))
    else $error("edge emitted without a full window");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fire3))
    else $error("output valid without a processed point");

endmodule

>>> verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lse_pkg::*;

  localparam int unsigned MAX_LINES     = 64;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam logic [THR_W-1:0]     THR_MAX      = 19'h7FFFF;
  localparam logic [INTEN_W-1:0]   INTEN_MAX    = 16'hFFFF;

  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SPARSE, RX_ALTERNATE} rx_mode_e;

  typedef struct {
    int x;
    int y;
    int z;
    int inten;
  } lpt_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [INTEN_W-1:0]        inten;
    logic [LINE_NUM_W-1:0]     line;
  } edge_pt_t;

  class edge_scoreboard;
    longint      depth_thr;
    longint      reach_thr;
    longint      step_thr;
    longint      gap_thr;
    int unsigned scan_cnt;
    lpt_t        win[2];
    int unsigned win_fill;
    bit          prev_neg;
    bit          have_prev;
    int unsigned cur_line;
    edge_pt_t    expected_edges[$];
    int unsigned errors;
    int unsigned edges_seen;
    int unsigned points_seen;

    function new();
      depth_thr = longint'(DEPTH_THR_RST);
      reach_thr = longint'(DIST_THR_RST);
      step_thr  = longint'(EDGE_THR_RST);
      gap_thr   = longint'(INTEN_THR_RST);
      scan_cnt  = 32'(SCAN_CNT_RST);
    endfunction

    function longint range_sq(lpt_t p);
      return longint'(p.x) * p.x + longint'(p.y) * p.y + longint'(p.z) * p.z;
    endfunction

    function int mag(int v);
      return v < 0 ? -v : v;
    endfunction

    function int unsigned pending();
      return expected_edges.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DEPTH_THR: depth_thr = longint'(data[THR_W-1:0]);
        REG_DIST_THR:  reach_thr = longint'(data[THR_W-1:0]);
        REG_EDGE_THR:  step_thr  = longint'(data[THR_W-1:0]);
        REG_INTEN_THR: gap_thr   = longint'(data[INTEN_W-1:0]);
        REG_SCAN_CNT:  scan_cnt  = 32'(data[SCAN_W-1:0]);
        default: ;
      endcase
    endfunction

    function void note_point(raw_pt_t raw);
      lpt_t        p;
      lpt_t        a;
      lpt_t        m;
      bit          neg;
      bit          pos;
      int unsigned limit;
      int          gi;
      int          dx;
      edge_pt_t    e;
      points_seen++;
      if (raw.frame_start) begin
        win_fill  = 0;
        prev_neg  = 1'b0;
        have_prev = 1'b0;
        cur_line  = 0;
      end
      if (!raw.finite) return;
      p.x = int'(raw.x);
      p.y = int'(raw.y);
      p.z = int'(raw.z);
      p.inten = int'(raw.inten);
      if (range_sq(p) <= depth_thr * depth_thr) return;
      neg = p.y < 0;
      pos = p.y > 0 || (p.y == 0 && p.x < 0);
      if (have_prev && prev_neg && pos) begin
        win_fill = 0;
        if (cur_line < MAX_LINES) cur_line++;
      end
      have_prev = 1'b1;
      prev_neg  = neg;
      limit = scan_cnt < MAX_LINES ? scan_cnt : MAX_LINES;
      if (cur_line >= limit) return;
      if (win_fill < 2) begin
        win[win_fill] = p;
        win_fill++;
        return;
      end
      a  = win[0];
      m  = win[1];
      gi = mag(a.inten - m.inten);
      if (mag(p.inten - m.inten) > gi) gi = mag(p.inten - m.inten);
      dx = a.x - m.x;
      if (p.x - m.x > dx) dx = p.x - m.x;
      if (m.x >= 0 && range_sq(m) <= reach_thr * reach_thr && gi > gap_thr && dx > step_thr) begin
        e.x     = COORD_W'(m.x);
        e.y     = COORD_W'(m.y);
        e.z     = COORD_W'(m.z);
        e.inten = INTEN_W'(m.inten);
        e.line  = cur_line[LINE_NUM_W-1:0];
        expected_edges = {expected_edges, e};
      end
      win[0] = win[1];
      win[1] = p;
    endfunction

    function void check_field(string name, longint want, longint got);
      if (want == got) return;
      errors++;
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
    endfunction

    function void check_edge(edge_pt_t got);
      edge_pt_t want;
      if (expected_edges.size() == 0) begin
        errors++;
        $display("%0t unexpected edge: expected none, actual x %0d y %0d z %0d int %0d line %0d",
                 $time, got.x, got.y, got.z, got.inten, got.line);
        return;
      end
      want = expected_edges.pop_front();
      edges_seen++;
      check_field("edge_x", longint'(want.x), longint'(got.x));
      check_field("edge_y", longint'(want.y), longint'(got.y));
      check_field("edge_z", longint'(want.z), longint'(got.z));
      check_field("edge_intensity", longint'(want.inten), longint'(got.inten));
      check_field("line_number", longint'(want.line), longint'(got.line));
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5ns clk_i = ~clk_i;

  lse_point_if pif();
  lse_edge_if  eif();
  lse_cfg_if   cif();

  lidar_scanline_edge_extractor #(
    .MAX_LINES(MAX_LINES)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .point_i(pif),
    .edge_o (eif),
    .cfg_i  (cif)
  );

  edge_scoreboard sb = new();
  raw_pt_t        mon_pt;
  edge_pt_t       mon_edge;
  int unsigned    burst_left;
  int unsigned    points_sent;
  int unsigned    hold_at;
  int unsigned    settings_used;
  bit             hold_off_req;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cif.valid && cif.ready) sb.write_reg(cif.index, cif.data);
      if (pif.valid && pif.ready) begin
        mon_pt.frame_start = pif.frame_start;
        mon_pt.finite      = pif.finite;
        mon_pt.x           = pif.x_coord;
        mon_pt.y           = pif.y_coord;
        mon_pt.z           = pif.z_coord;
        mon_pt.inten       = pif.intensity;
        sb.note_point(mon_pt);
      end
      if (eif.valid && eif.ready) begin
        mon_edge.x     = eif.edge_x;
        mon_edge.y     = eif.edge_y;
        mon_edge.z     = eif.edge_z;
        mon_edge.inten = eif.edge_intensity;
        mon_edge.line  = eif.line_number;
        sb.check_edge(mon_edge);
      end
    end
  end

  task automatic send_point(raw_pt_t p);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        pif.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    pif.valid       <= 1'b1;
    pif.frame_start <= p.frame_start;
    pif.finite      <= p.finite;
    pif.x_coord     <= p.x;
    pif.y_coord     <= p.y;
    pif.z_coord     <= p.z;
    pif.intensity   <= p.inten;
    @(posedge clk_i);
    while (!pif.ready) @(posedge clk_i);
    burst_left--;
    points_sent++;
    if (points_sent == hold_at) hold_off_req = 1'b1;
  endtask

  function automatic raw_pt_t make_point(bit fs, bit neg_side, bit allow_stray);
    raw_pt_t     p;
    int unsigned kind;
    kind          = $urandom_range(0, 99);
    p.frame_start = fs || (allow_stray && $urandom_range(0, 49) == 0);
    p.finite      = kind >= 6;
    p.inten       = INTEN_W'($urandom);
    if (kind < 12) begin
      p.x = COORD_W'($urandom);
      p.y = COORD_W'($urandom);
      p.z = COORD_W'($urandom);
    end else if (kind < 17) begin
      p.x = COORD_W'(int'($urandom_range(0, 6)) - 3);
      p.y = COORD_W'(int'($urandom_range(0, 6)) - 3);
      p.z = COORD_W'(int'($urandom_range(0, 6)) - 3);
    end else begin
      p.x = COORD_W'(($urandom_range(0, 9) == 0) ? -int'($urandom_range(1, 3000))
                                                 : int'($urandom_range(0, 3000)));
      if ($urandom_range(0, 29) == 0)
        p.y = '0;
      else
        p.y = COORD_W'(neg_side ? -int'($urandom_range(1, 4000))
                                : int'($urandom_range(1, 4000)));
      p.z = COORD_W'(int'($urandom_range(0, 2000)) - 1000);
    end
    return p;
  endfunction

  // sweep each scan line from positive to negative y so the line counter advances
  task automatic run_frames(int unsigned n_points, int unsigned min_lines,
                            int unsigned max_lines, int unsigned min_pts,
                            int unsigned max_pts, bit allow_stray);
    int unsigned lines;
    int unsigned pts;
    int unsigned sent;
    sent = 0;
    while (sent < n_points) begin
      lines = $urandom_range(min_lines, max_lines);
      for (int l = 0; l < lines; l++) begin
        pts = $urandom_range(min_pts, max_pts);
        for (int k = 0; k < pts; k++) begin
          send_point(make_point(l == 0 && k == 0, k >= (pts + 1) / 2, allow_stray));
          sent++;
        end
      end
    end
  endtask

  task automatic drain_pipeline();
    pif.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cif.valid <= 1'b1;
    cif.index <= idx;
    cif.data  <= data;
    @(posedge clk_i);
    while (!cif.ready) @(posedge clk_i);
  endtask

  task automatic set_config(int unsigned depth_mm, int unsigned reach_mm,
                            int unsigned step_mm, int unsigned gap, int unsigned lines);
    write_reg(REG_DEPTH_THR, CFG_DATA_W'(depth_mm));
    write_reg(REG_DIST_THR, CFG_DATA_W'(reach_mm));
    write_reg(REG_EDGE_THR, CFG_DATA_W'(step_mm));
    write_reg(REG_INTEN_THR, CFG_DATA_W'(gap));
    write_reg(REG_SCAN_CNT, CFG_DATA_W'(lines));
    write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
    cif.valid <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  initial begin
    rx_mode_e    mode;
    int unsigned stretch;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        eif.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        mode    = rx_mode_e'($urandom_range(0, 3));
        stretch = $urandom_range(8, 40);
        for (int c = 0; c < stretch && !hold_off_req; c++) begin
          case (mode)
            RX_OPEN:   eif.ready <= 1'b1;
            RX_COIN:   eif.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: eif.ready <= ($urandom_range(0, 3) == 0);
            default:   eif.ready <= c[0];
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    #3ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    pif.valid       = 1'b0;
    pif.frame_start = 1'b0;
    pif.finite      = 1'b0;
    pif.x_coord     = '0;
    pif.y_coord     = '0;
    pif.z_coord     = '0;
    pif.intensity   = '0;
    eif.ready       = 1'b0;
    cif.valid       = 1'b0;
    cif.index       = '0;
    cif.data        = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_point('{1'b1, 1'b1, 100, 50, 7, 1000});
    send_point('{1'b0, 1'b1, 10, 60, -7, 5000});
    send_point('{1'b0, 1'b1, 200, 70, 0, 0});
    send_point('{1'b0, 1'b0, -524288, 524287, -1, 65535});
    send_point('{1'b0, 1'b1, 0, 0, 0, 123});
    send_point('{1'b0, 1'b1, 524287, -1, -524288, 65535});
    send_point('{1'b0, 1'b1, 0, 0, 5, 0});
    send_point('{1'b0, 1'b1, -5, 0, 0, 40000});
    send_point('{1'b0, 1'b1, 300, -10, 0, 100});
    send_point('{1'b0, 1'b1, -524288, 524287, 524287, 0});
    send_point('{1'b0, 1'b1, -524288, -524288, -524288, 65535});
    send_point('{1'b0, 1'b1, 1, 2, 3, 65535});
    send_point('{1'b0, 1'b1, 0, 5, 0, 0});
    send_point('{1'b0, 1'b1, 50, 5, 0, 65535});
    send_point('{1'b1, 1'b0, 1, 1, 1, 1});
    send_point('{1'b0, 1'b1, 20, -5, 0, 10});
    send_point('{1'b0, 1'b1, 5, 5, 0, 20});
    drain_pipeline();

    // range boundaries: exactly at the depth limit drops, exactly at the distance limit keeps
    set_config(4, 5, 0, 0, 64);
    send_point('{1'b1, 1'b1, 10, 1, 0, 100});
    send_point('{1'b0, 1'b1, 3, 4, 0, 0});
    send_point('{1'b0, 1'b1, 10, 2, 0, 100});
    send_point('{1'b0, 1'b1, 0, 4, 0, 9});
    send_point('{1'b0, 1'b1, 3, 4, 1, 0});
    send_point('{1'b0, 1'b1, 20, 1, 0, 500});
    drain_pipeline();

    set_config(0, THR_MAX, 0, 0, MAX_LINES);
    hold_at = points_sent + 40;
    run_frames(198, 66, 66, 3, 3, 1'b0);
    drain_pipeline();

    set_config($urandom_range(0, 500), $urandom_range(1500, 6000), $urandom_range(0, 1500),
               $urandom_range(0, 40000), $urandom_range(2, 8));
    run_frames(80, 2, 6, 3, 8, 1'b1);
    drain_pipeline();

    set_config(THR_MAX, 0, THR_MAX, INTEN_MAX, 1);
    run_frames(30, 1, 3, 3, 6, 1'b1);
    drain_pipeline();

    set_config(0, THR_MAX, 0, 0, 1);
    run_frames(60, 2, 4, 3, 8, 1'b1);
    drain_pipeline();

    set_config($urandom_range(0, 300), $urandom_range(2000, 524287), $urandom_range(0, 800),
               $urandom_range(0, 65535), $urandom_range(1, MAX_LINES));
    run_frames(80, 1, 8, 3, 10, 1'b1);
    drain_pipeline();

    $display("Covered %0d points and %0d edge checks over %0d register settings,",
             sb.points_seen, sb.edges_seen, settings_used);
    $display("including a long output stall, line overflow and threshold extremes.");
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
